FILE: src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and functions of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int WORD_W     = 32;
    localparam int WIN_DEPTH  = 16;
    localparam int WIN_AW     = 4;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CMP,
        ST_FIN,
        ST_OUT
    } t_state;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

FILE: src/sha256_ram.sv
// ----------------------------------------------------------------------------
// sha256_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module sha256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: src/sha256_message_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// Byte-serial SHA-256: packs bytes into a 16-word window memory, runs one
// round per cycle over it and emits the eight digest words.
// ----------------------------------------------------------------------------
// Byte word: the 64th byte of a block also starts a compression: the round
// loop over the window memory, then the hash update.
// End word: one or two compressions, each a window fill, round loop and hash
// update; then eight result words, one per cycle while not stalled.
// Reset: synchronous active low; restores the initial hash, clears count.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core
    import sha256_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_state      r_state, n_state;
    logic [31:0] r_hash [8];
    logic [31:0] n_hash [8];
    logic [31:0] r_wv [8];
    logic [31:0] n_wv [8];
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [23:0] r_acc, n_acc;
    logic [6:0]  r_rc, n_rc;
    logic [3:0]  r_widx, n_widx;
    logic        r_first, n_first;
    logic        r_end, n_end;
    logic        r_lenblk, n_lenblk;
    logic [2:0]  r_oidx, n_oidx;

    logic        in_acc, out_acc;
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;
    logic [3:0]  ra_a, ra_b, ra_c, ra_d;
    logic [31:0] q_a, q_b, q_c, q_d;
    logic [5:0]  t_rnd;
    logic [31:0] w_cur, t1, t2, merge_word, fill_word;

    sha256_ram #(.WIDTH(WORD_W), .DEPTH(WIN_DEPTH)) u_win_lo (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra_a), .i_raddr_b(ra_b), .o_rdata_a(q_a), .o_rdata_b(q_b)
    );

    sha256_ram #(.WIDTH(WORD_W), .DEPTH(WIN_DEPTH)) u_win_hi (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra_c), .i_raddr_b(ra_d), .o_rdata_a(q_c), .o_rdata_b(q_d)
    );

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        o_out_word.digest_word = r_hash[r_oidx];
        o_out_word.word_index  = r_oidx;
        o_out_word.last_word   = (r_oidx == 3'd7);
    end

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.kind) begin
                        n_state = ST_FILL;
                    end else if (r_fill == 6'd63) begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_FILL: begin
                if (r_widx == 4'd15) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (r_rc == 7'd64) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_end) begin
                    n_state = ST_IDLE;
                end else if (r_lenblk) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_OUT: begin
                if (out_acc && r_oidx == 3'd7) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_fill[1:0])
            2'd0:    merge_word = {PAD_MARK, 24'h0};
            2'd1:    merge_word = {r_acc[7:0], PAD_MARK, 16'h0};
            2'd2:    merge_word = {r_acc[15:0], PAD_MARK, 8'h0};
            default: merge_word = {r_acc[23:0], PAD_MARK};
        endcase
        if (r_first) begin
            fill_word = merge_word;
        end else if (r_lenblk && r_widx == 4'd14) begin
            fill_word = r_bits[63:32];
        end else if (r_lenblk && r_widx == 4'd15) begin
            fill_word = r_bits[31:0];
        end else begin
            fill_word = 32'h0;
        end
    end

    always_comb begin
        ra_a  = r_rc[3:0];
        ra_b  = r_rc[3:0] - 4'd2;
        ra_c  = r_rc[3:0] - 4'd7;
        ra_d  = r_rc[3:0] - 4'd15;
        t_rnd = r_rc[5:0] - 6'd1;
        if (t_rnd[5:4] == 2'd0) begin
            w_cur = q_a;
        end else begin
            w_cur = sig1(q_b) + q_c + sig0(q_d) + q_a;
        end
        t1 = r_wv[7] + bsig1(r_wv[4]) + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
           + ROUND_K[t_rnd] + w_cur;
        t2 = bsig0(r_wv[0])
           + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));
    end

    always_comb begin
        n_hash   = r_hash;
        n_wv     = r_wv;
        n_fill   = r_fill;
        n_bits   = r_bits;
        n_acc    = r_acc;
        n_rc     = r_rc;
        n_widx   = r_widx;
        n_first  = r_first;
        n_end    = r_end;
        n_lenblk = r_lenblk;
        n_oidx   = r_oidx;
        we       = 1'b0;
        waddr    = r_widx;
        wdata    = fill_word;
        case (r_state)
            ST_IDLE: begin
                n_rc   = 7'd0;
                n_oidx = 3'd0;
                if (in_acc) begin
                    if (i_in_word.kind) begin
                        n_widx   = r_fill[5:2];
                        n_first  = 1'b1;
                        n_end    = 1'b1;
                        n_lenblk = (r_fill < LEN_OFFSET);
                    end else begin
                        n_acc  = {r_acc[15:0], i_in_word.data_byte};
                        n_fill = r_fill + 6'd1;
                        n_bits = r_bits + 64'd8;
                        n_end  = 1'b0;
                        if (r_fill[1:0] == 2'd3) begin
                            we    = 1'b1;
                            waddr = r_fill[5:2];
                            wdata = {r_acc, i_in_word.data_byte};
                        end
                    end
                end
            end
            ST_FILL: begin
                we      = 1'b1;
                n_first = 1'b0;
                n_widx  = r_widx + 4'd1;
                n_rc    = 7'd0;
            end
            ST_CMP: begin
                n_rc = r_rc + 7'd1;
                if (r_rc == 7'd0) begin
                    n_wv = r_hash;
                end else begin
                    if (t_rnd[5:4] != 2'd0) begin
                        we    = 1'b1;
                        waddr = t_rnd[3:0];
                        wdata = w_cur;
                    end
                    n_wv[7] = r_wv[6];
                    n_wv[6] = r_wv[5];
                    n_wv[5] = r_wv[4];
                    n_wv[4] = r_wv[3] + t1;
                    n_wv[3] = r_wv[2];
                    n_wv[2] = r_wv[1];
                    n_wv[1] = r_wv[0];
                    n_wv[0] = t1 + t2;
                end
            end
            ST_FIN: begin
                for (int i = 0; i < 8; i++) begin
                    n_hash[i] = r_hash[i] + r_wv[i];
                end
                n_widx   = 4'd0;
                n_lenblk = 1'b1;
                n_oidx   = 3'd0;
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_hash = HASH_IV;
                        n_fill = 6'd0;
                        n_bits = 64'd0;
                        n_end  = 1'b0;
                    end
                end
            end
            default: begin
                n_rc = 7'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_hash   <= HASH_IV;
            r_fill   <= 6'd0;
            r_bits   <= 64'd0;
            r_rc     <= 7'd0;
            r_widx   <= 4'd0;
            r_first  <= 1'b0;
            r_end    <= 1'b0;
            r_lenblk <= 1'b0;
            r_oidx   <= 3'd0;
        end else begin
            r_state  <= n_state;
            r_hash   <= n_hash;
            r_fill   <= n_fill;
            r_bits   <= n_bits;
            r_rc     <= n_rc;
            r_widx   <= n_widx;
            r_first  <= n_first;
            r_end    <= n_end;
            r_lenblk <= n_lenblk;
            r_oidx   <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wv  <= n_wv;
        r_acc <= n_acc;
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of sha256_message_hasher_core: feeds message bytes and end words,
// predicts each digest with a behavioral SHA-256 and compares every result
// word against the oldest predicted one, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb
    import sha256_pkg::*;
();

    class digest_board;
        logic [31:0] hash_state [8];
        logic [7:0]  msg_block [64];
        int          fill;
        logic [63:0] bit_count;
        t_out_word   pending [$];
        int          errors;

        function new();
            reset_hash();
            fill = 0;
            bit_count = '0;
            errors = 0;
        endfunction

        function void reset_hash();
            hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            v = hash_state;
            for (int t = 0; t < 64; t++) begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hash_state[i] += v[i];
        endfunction

        function void note_word(t_in_word iw);
            t_out_word ow;
            if (!iw.kind) begin
                msg_block[fill] = iw.data_byte;
                bit_count += 64'd8;
                fill++;
                if (fill == 64) begin
                    compress();
                    fill = 0;
                end
                return;
            end
            msg_block[fill] = PAD_MARK;
            for (int i = fill + 1; i < 64; i++) msg_block[i] = 8'h00;
            if (fill >= 56) begin
                compress();
                for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) msg_block[56+i] = bit_count[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                ow.digest_word = hash_state[i];
                ow.word_index  = 3'(i);
                ow.last_word   = (i == 7);
                pending.push_back(ow);
            end
            reset_hash();
            fill = 0;
            bit_count = '0;
        endfunction

        function void check_word(t_out_word got);
            t_out_word exp_w;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.digest_word !== exp_w.digest_word) begin
                $error("digest_word expected %h actual %h", exp_w.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== exp_w.word_index) begin
                $error("word_index expected %0d actual %0d", exp_w.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== exp_w.last_word) begin
                $error("last_word expected %0d actual %0d", exp_w.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 4000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    digest_board board = new();
    int idle_cycles = 0;
    int stall_mode = 0;
    int burst_left = 0;

    sha256_message_hasher_core dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.note_word(i_in_word);
            if (o_out_valid && !i_out_stall) board.check_word(o_out_word);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sha256_message_hasher_core verification failed");
                $finish;
            end
        end
    end

    // receiver stall pattern: phases of none, heavy, light
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_word(input logic kind, input logic [7:0] data);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= '{kind: kind, data_byte: data};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_message(input int len, input int fill_kind);
        for (int i = 0; i < len; i++)
            case (fill_kind)
                0: send_word(1'b0, 8'h00);
                1: send_word(1'b0, 8'hff);
                default: send_word(1'b0, 8'($urandom));
            endcase
        send_word(1'b1, 8'($urandom));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int len;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_message(0, 2);
        send_message(3, 1);
        send_message(60, 2);
        send_message(64, 0);
        drain();
        send_message(2, 2);
        for (int m = 0; m < 3; m++) begin
            case ($urandom_range(0, 3))
                0: len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            send_message(len, 2);
        end
        drain();
        repeat (200) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("sha256_message_hasher_core verification clean");
        else
            $display("sha256_message_hasher_core verification failed");
        $finish;
    end
endmodule

FILE: files.f
src/sha256_pkg.sv
src/sha256_ram.sv
src/sha256_message_hasher_core.sv
bench/tb.sv
